@@ design/msgpack_stream_decoder_top_defines.svh @@
// Assertion macros for the MessagePack stream decoder.
// Expects clk and rst_n in the scope of every use.
`ifndef MSGPACK_STREAM_DECODER_TOP_DEFINES_SVH
`define MSGPACK_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSGD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication, disabled during reset
`define MSGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/msgd_pkg.sv @@
// Shared types, codes and constants of the MessagePack stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package msgd_pkg;

    localparam int MAX_NESTING_DEF = 16;
    localparam int DEPTH_W         = 5;
    localparam int CNT_W           = 32;
    localparam int ELEM_W          = 33;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 5'd16;
    localparam logic REG_MAX_DEPTH = 1'b0;

    localparam logic [7:0] LD_FIXMAP = 8'h80;
    localparam logic [7:0] LD_FIXARR = 8'h90;
    localparam logic [7:0] LD_FIXRAW = 8'ha0;
    localparam logic [7:0] LD_NIL    = 8'hc0;
    localparam logic [7:0] LD_FALSE  = 8'hc2;
    localparam logic [7:0] LD_TRUE   = 8'hc3;
    localparam logic [7:0] LD_F32    = 8'hca;
    localparam logic [7:0] LD_F64    = 8'hcb;
    localparam logic [7:0] LD_U8     = 8'hcc;
    localparam logic [7:0] LD_U16    = 8'hcd;
    localparam logic [7:0] LD_U32    = 8'hce;
    localparam logic [7:0] LD_U64    = 8'hcf;
    localparam logic [7:0] LD_I8     = 8'hd0;
    localparam logic [7:0] LD_I16    = 8'hd1;
    localparam logic [7:0] LD_I32    = 8'hd2;
    localparam logic [7:0] LD_I64    = 8'hd3;
    localparam logic [7:0] LD_RAW16  = 8'hda;
    localparam logic [7:0] LD_RAW32  = 8'hdb;
    localparam logic [7:0] LD_ARR16  = 8'hdc;
    localparam logic [7:0] LD_ARR32  = 8'hdd;
    localparam logic [7:0] LD_MAP16  = 8'hde;
    localparam logic [7:0] LD_MAP32  = 8'hdf;
    localparam logic [7:0] LD_NEGFIX = 8'he0;

    typedef enum logic [3:0] {
        K_UINT  = 4'd0,
        K_INT   = 4'd1,
        K_NIL   = 4'd2,
        K_TRUE  = 4'd3,
        K_FALSE = 4'd4,
        K_F32   = 4'd5,
        K_F64   = 4'd6,
        K_ARRAY = 4'd7,
        K_MAP   = 4'd8,
        K_BYTES = 4'd9,
        K_BYTE  = 4'd10,
        K_BAD   = 4'd11,
        K_TRUNC = 4'd12,
        K_DEEP  = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        PH_LEADER  = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [63:0]         value;
        logic [CNT_W-1:0]    length;
        logic [7:0]          leader;
        logic [DEPTH_W-1:0]  depth;
        logic [DEPTH_W-1:0]  levels_closed;
        logic                top_done;
    } out_item_t;

    typedef struct packed {
        logic              push;
        logic              finish;
        logic              clear;
        logic [ELEM_W-1:0] elems;
    } stk_ctl_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] closed;
        logic               top;
    } stk_stat_t;

    // usable stack entries: the depth fields cap nesting at 31
    function automatic int stk_size(input int n);
        return (n < 31) ? n : 31;
    endfunction

endpackage

@@ design/msgd_stack.sv @@
// Stack of remaining-element counts, one register cell per nesting level.
// Depends on msgd_pkg.
`timescale 1ns / 1ps

module msgd_stack #(
    parameter int MAX_NESTING = msgd_pkg::MAX_NESTING_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  msgd_pkg::stk_ctl_t  ctl,
    output msgd_pkg::stk_stat_t stat
);

    localparam int STK = msgd_pkg::stk_size(MAX_NESTING);
    localparam int IW  = (STK > 1) ? $clog2(STK) : 1;

    logic [msgd_pkg::ELEM_W-1:0]  ent_reg [STK];
    logic [msgd_pkg::DEPTH_W-1:0] depth_reg;
    logic [msgd_pkg::DEPTH_W-1:0] depth_next;
    logic                         found;
    logic [IW-1:0]                hidx;
    logic [msgd_pkg::DEPTH_W-1:0] closed;

    // highest open level that does not complete on this value
    always_comb
    begin
        found = 1'b0;
        hidx  = '0;
        for (int i = 0; i < STK; i++)
        begin
            if ((msgd_pkg::DEPTH_W'(i) < depth_reg) && (ent_reg[i] != 33'd1))
            begin
                found = 1'b1;
                hidx  = IW'(i);
            end
        end
        closed = found ? (depth_reg - 5'd1 - msgd_pkg::DEPTH_W'(hidx)) : depth_reg;
    end

    assign stat.depth  = depth_reg;
    assign stat.closed = closed;
    assign stat.top    = !found;

    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.clear)
        begin
            depth_next = '0;
        end
        else if (ctl.push)
        begin
            depth_next = depth_reg + 5'd1;
        end
        else if (ctl.finish)
        begin
            depth_next = depth_reg - closed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STK; i++)
        begin
            if (!ctl.clear && ctl.push && (depth_reg == msgd_pkg::DEPTH_W'(i)))
            begin
                ent_reg[i] <= ctl.elems;
            end
            else if (!ctl.clear && ctl.finish && found && (hidx == IW'(i)))
            begin
                ent_reg[i] <= ent_reg[i] - 33'd1;
            end
        end
    end

endmodule

@@ design/msgd_step.sv @@
// Per-byte decode: leader, header and payload phases, token build, truncation.
// Depends on msgd_pkg; drives msgd_stack through a control struct.
`timescale 1ns / 1ps

module msgd_step #(
    parameter int MAX_NESTING = msgd_pkg::MAX_NESTING_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  msgd_pkg::in_item_t           item,
    input  logic [msgd_pkg::DEPTH_W-1:0] max_depth,
    input  msgd_pkg::stk_stat_t          stat,
    output msgd_pkg::stk_ctl_t           ctl,
    output logic                         tok_have,
    output msgd_pkg::out_item_t          tok
);

    localparam int STK = msgd_pkg::stk_size(MAX_NESTING);
    localparam logic [msgd_pkg::DEPTH_W-1:0] STK_DEPTH = msgd_pkg::DEPTH_W'(STK);

    msgd_pkg::phase_t             phase_reg, phase_next;
    logic [msgd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]                  shift_reg, shift_next;
    logic [7:0]                   lead_reg, lead_next;

    logic [7:0]                   b;
    logic [63:0]                  v;
    logic [msgd_pkg::DEPTH_W-1:0] limit;
    logic [msgd_pkg::DEPTH_W-1:0] depth_after;
    logic                         scalar_req, open_req, bytes_req, err_bad, err_deep, trunc;
    logic                         do_finish, do_push, do_clear;
    msgd_pkg::kind_t              req_kind;
    logic [63:0]                  req_value;
    logic [msgd_pkg::CNT_W-1:0]   req_count;
    logic [msgd_pkg::ELEM_W-1:0]  req_elems;

    assign b     = item.data_byte;
    assign v     = {shift_reg[55:0], b};
    assign limit = (max_depth < STK_DEPTH) ? max_depth : STK_DEPTH;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        lead_next  = lead_reg;
        scalar_req = 1'b0;
        open_req   = 1'b0;
        bytes_req  = 1'b0;
        err_bad    = 1'b0;
        err_deep   = 1'b0;
        req_kind   = msgd_pkg::K_UINT;
        req_value  = '0;
        req_count  = '0;
        req_elems  = '0;
        do_finish  = 1'b0;
        do_push    = 1'b0;
        do_clear   = 1'b0;
        tok_have   = 1'b0;
        tok        = '0;
        tok.depth  = stat.depth;

        case (phase_reg)
            msgd_pkg::PH_HEADER:
            begin
                shift_next = v;
                cnt_next   = cnt_reg - 32'd1;
                if (cnt_reg == 32'd1)
                begin
                    phase_next = msgd_pkg::PH_LEADER;
                    case (lead_reg)
                        msgd_pkg::LD_F32:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_F32;
                            req_value  = {32'd0, v[31:0]};
                        end
                        msgd_pkg::LD_F64:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_F64;
                            req_value  = v;
                        end
                        msgd_pkg::LD_U8, msgd_pkg::LD_U16, msgd_pkg::LD_U32, msgd_pkg::LD_U64:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_UINT;
                            req_value  = v;
                        end
                        msgd_pkg::LD_I8:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_INT;
                            req_value  = {{56{v[7]}}, v[7:0]};
                        end
                        msgd_pkg::LD_I16:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_INT;
                            req_value  = {{48{v[15]}}, v[15:0]};
                        end
                        msgd_pkg::LD_I32:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_INT;
                            req_value  = {{32{v[31]}}, v[31:0]};
                        end
                        msgd_pkg::LD_I64:
                        begin
                            scalar_req = 1'b1;
                            req_kind   = msgd_pkg::K_INT;
                            req_value  = v;
                        end
                        msgd_pkg::LD_RAW16, msgd_pkg::LD_RAW32:
                        begin
                            bytes_req = 1'b1;
                            req_count = v[31:0];
                        end
                        msgd_pkg::LD_ARR16, msgd_pkg::LD_ARR32:
                        begin
                            open_req  = 1'b1;
                            req_kind  = msgd_pkg::K_ARRAY;
                            req_count = v[31:0];
                            req_elems = {1'b0, v[31:0]};
                        end
                        msgd_pkg::LD_MAP16, msgd_pkg::LD_MAP32:
                        begin
                            open_req  = 1'b1;
                            req_kind  = msgd_pkg::K_MAP;
                            req_count = v[31:0];
                            req_elems = {v[31:0], 1'b0};
                        end
                        default:
                        begin
                            err_bad = 1'b1;
                        end
                    endcase
                end
            end
            msgd_pkg::PH_PAYLOAD:
            begin
                tok_have   = 1'b1;
                tok.kind   = msgd_pkg::K_BYTE;
                tok.value  = {56'd0, b};
                cnt_next   = cnt_reg - 32'd1;
                if (cnt_reg == 32'd1)
                begin
                    phase_next = msgd_pkg::PH_LEADER;
                    do_finish  = 1'b1;
                end
            end
            default:
            begin
                lead_next = b;
                case (b) inside
                    [8'h00 : msgd_pkg::LD_FIXMAP - 8'd1], [msgd_pkg::LD_NEGFIX : 8'hff]:
                    begin
                        scalar_req = 1'b1;
                        req_kind   = msgd_pkg::K_INT;
                        req_value  = {{56{b[7]}}, b};
                    end
                    [msgd_pkg::LD_FIXMAP : msgd_pkg::LD_FIXARR - 8'd1]:
                    begin
                        open_req  = 1'b1;
                        req_kind  = msgd_pkg::K_MAP;
                        req_count = {28'd0, b[3:0]};
                        req_elems = {28'd0, b[3:0], 1'b0};
                    end
                    [msgd_pkg::LD_FIXARR : msgd_pkg::LD_FIXRAW - 8'd1]:
                    begin
                        open_req  = 1'b1;
                        req_kind  = msgd_pkg::K_ARRAY;
                        req_count = {28'd0, b[3:0]};
                        req_elems = {29'd0, b[3:0]};
                    end
                    [msgd_pkg::LD_FIXRAW : msgd_pkg::LD_NIL - 8'd1]:
                    begin
                        bytes_req = 1'b1;
                        req_count = {27'd0, b[4:0]};
                    end
                    msgd_pkg::LD_NIL:
                    begin
                        scalar_req = 1'b1;
                        req_kind   = msgd_pkg::K_NIL;
                    end
                    msgd_pkg::LD_FALSE:
                    begin
                        scalar_req = 1'b1;
                        req_kind   = msgd_pkg::K_FALSE;
                    end
                    msgd_pkg::LD_TRUE:
                    begin
                        scalar_req = 1'b1;
                        req_kind   = msgd_pkg::K_TRUE;
                    end
                    msgd_pkg::LD_F32, msgd_pkg::LD_U32, msgd_pkg::LD_I32, msgd_pkg::LD_RAW32,
                    msgd_pkg::LD_ARR32, msgd_pkg::LD_MAP32:
                    begin
                        phase_next = msgd_pkg::PH_HEADER;
                        cnt_next   = 32'd4;
                        shift_next = '0;
                    end
                    msgd_pkg::LD_F64, msgd_pkg::LD_U64, msgd_pkg::LD_I64:
                    begin
                        phase_next = msgd_pkg::PH_HEADER;
                        cnt_next   = 32'd8;
                        shift_next = '0;
                    end
                    msgd_pkg::LD_U8, msgd_pkg::LD_I8:
                    begin
                        phase_next = msgd_pkg::PH_HEADER;
                        cnt_next   = 32'd1;
                        shift_next = '0;
                    end
                    msgd_pkg::LD_U16, msgd_pkg::LD_I16, msgd_pkg::LD_RAW16,
                    msgd_pkg::LD_ARR16, msgd_pkg::LD_MAP16:
                    begin
                        phase_next = msgd_pkg::PH_HEADER;
                        cnt_next   = 32'd2;
                        shift_next = '0;
                    end
                    default:
                    begin
                        err_bad = 1'b1;
                    end
                endcase
            end
        endcase

        if (scalar_req)
        begin
            tok_have  = 1'b1;
            tok.kind  = req_kind;
            tok.value = req_value;
            do_finish = 1'b1;
        end
        if (open_req)
        begin
            tok_have   = 1'b1;
            tok.kind   = req_kind;
            tok.length = req_count;
            if (req_elems == '0)
            begin
                do_finish = 1'b1;
            end
            else if (stat.depth >= limit)
            begin
                err_deep = 1'b1;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
        if (bytes_req)
        begin
            tok_have   = 1'b1;
            tok.kind   = msgd_pkg::K_BYTES;
            tok.length = req_count;
            if (req_count == '0)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                phase_next = msgd_pkg::PH_PAYLOAD;
                cnt_next   = req_count;
            end
        end
        if (do_finish)
        begin
            tok.levels_closed = stat.closed;
            tok.top_done      = stat.top;
        end

        depth_after = do_push ? (stat.depth + 5'd1)
                    : (do_finish ? (stat.depth - stat.closed) : stat.depth);

        if (err_bad || err_deep)
        begin
            tok_have          = 1'b1;
            tok.kind          = err_bad ? msgd_pkg::K_BAD : msgd_pkg::K_DEEP;
            tok.value         = {56'd0, b};
            tok.levels_closed = '0;
            tok.top_done      = 1'b0;
            do_clear          = 1'b1;
        end

        trunc = item.last_byte && !do_clear &&
                ((phase_next != msgd_pkg::PH_LEADER) || (depth_after != '0));
        if (trunc)
        begin
            tok_have          = 1'b1;
            tok.kind          = msgd_pkg::K_TRUNC;
            tok.value         = {56'd0, b};
            tok.length        = '0;
            tok.depth         = depth_after;
            tok.levels_closed = '0;
            tok.top_done      = 1'b0;
            do_clear          = 1'b1;
        end

        if (do_clear)
        begin
            phase_next = msgd_pkg::PH_LEADER;
            cnt_next   = '0;
            shift_next = '0;
        end
        tok.leader = lead_next;
    end

    assign ctl.push   = en && do_push && !do_clear;
    assign ctl.finish = en && do_finish && !do_clear;
    assign ctl.clear  = en && do_clear;
    assign ctl.elems  = req_elems;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= msgd_pkg::PH_LEADER;
            cnt_reg   <= '0;
            shift_reg <= '0;
            lead_reg  <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            lead_reg  <= lead_next;
        end
    end

endmodule

@@ design/msgpack_stream_decoder_top.sv @@
// MessagePack stream decoder, top level: request registers, APB register, assembly.
// Depends on msgd_pkg, msgd_step, msgd_stack and msgpack_stream_decoder_top_defines.svh.
`timescale 1ns / 1ps

// Decodes a legacy-raw MessagePack byte stream at one byte per clock, with zero
// or one token per byte. A byte passes an input register, then one combinational
// decode step (stack pop search over min(MAX_NESTING, 31) levels) into the output
// register, a new byte every cycle while out_ready holds. max_depth (APB offset
// 0x0, reset 16) limits nesting; write it only while idle.
`include "msgpack_stream_decoder_top_defines.svh"

module msgpack_stream_decoder_top #(
    parameter int MAX_NESTING = msgd_pkg::MAX_NESTING_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msgd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output msgd_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                          in_valid_reg;
    msgd_pkg::in_item_t            in_item_reg;
    logic                          out_valid_reg;
    msgd_pkg::out_item_t           out_item_reg;
    logic [msgd_pkg::DEPTH_W-1:0]  max_depth_reg;
    logic                          advance;
    logic                          cfg_wr;
    logic                          tok_have;
    msgd_pkg::out_item_t           tok;
    msgd_pkg::stk_ctl_t            stk_ctl;
    msgd_pkg::stk_stat_t           stk_stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == msgd_pkg::REG_MAX_DEPTH);
    assign prdata    = (paddr[2] == msgd_pkg::REG_MAX_DEPTH) ? {27'd0, max_depth_reg} : '0;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= msgd_pkg::MAX_DEPTH_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                max_depth_reg <= pwdata[msgd_pkg::DEPTH_W-1:0];
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= tok_have;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= tok;
        end
    end

    msgd_step #(
        .MAX_NESTING (MAX_NESTING)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .item      (in_item_reg),
        .max_depth (max_depth_reg),
        .stat      (stk_stat),
        .ctl       (stk_ctl),
        .tok_have  (tok_have),
        .tok       (tok)
    );

    msgd_stack #(
        .MAX_NESTING (MAX_NESTING)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stk_ctl),
        .stat  (stk_stat)
    );

    `MSGD_ASSERT(a_top_closes_all, (out_valid_reg && out_item_reg.top_done) |-> (out_item_reg.levels_closed == out_item_reg.depth), "top-level completion without closing every open level")
    `MSGD_ASSERT(a_err_no_close, (out_valid_reg && (out_item_reg.kind == msgd_pkg::K_BAD || out_item_reg.kind == msgd_pkg::K_TRUNC || out_item_reg.kind == msgd_pkg::K_DEEP)) |-> (out_item_reg.levels_closed == '0 && !out_item_reg.top_done), "error token reports closed levels")
    `MSGD_ASSERT(a_stall_cause, !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready), "input stalled without a blocked result")
    `MSGD_ASSERT_NEXT(a_cfg_write, cfg_wr, max_depth_reg == $past(pwdata[msgd_pkg::DEPTH_W-1:0]), "max_depth write lost")

endmodule

@@ verif/msgpack_stream_decoder_top_tb.sv @@
// Testbench for the MessagePack stream decoder: directed and random byte streams,
// a behavioral token predictor, in-order token checking, and APB max_depth settings.
// Depends on msgd_pkg and msgpack_stream_decoder_top.
`timescale 1ns / 1ps

module msgpack_stream_decoder_top_tb;
    import msgd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam int NEST = 16;
    localparam int CYCLE_LIMIT = 1500000;

    msgpack_stream_decoder_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [32:0] rem_count [NEST];
    logic [4:0]  open_levels;
    logic [63:0] hdr_bits;
    logic [32:0] hdr_left;
    phase_t      phase;
    logic [7:0]  cur_leader;
    logic [4:0]  depth_limit;

    out_item_t   token_queue[$];
    int          fail_count;
    int          token_count;
    int          byte_count;
    int          cycle_count;
    bit          stall_quiet;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
        logic [63:0] r;
        r = v;
        if (bits < 64 && v[bits-1])
            r = v | (~64'd0 << bits);
        return r;
    endfunction

    function automatic void clear_parser();
        for (int i = 0; i < NEST; i++)
            rem_count[i] = '0;
        open_levels = '0;
        hdr_bits = '0;
        hdr_left = '0;
        phase = PH_LEADER;
    endfunction

    function automatic void close_value(inout out_item_t t);
        logic [4:0] closed;
        closed = '0;
        t.top_done = 1'b0;
        forever
        begin
            if (open_levels == 0)
            begin
                t.top_done = 1'b1;
                break;
            end
            rem_count[open_levels-1] = rem_count[open_levels-1] - 33'd1;
            if (rem_count[open_levels-1] != 0)
                break;
            open_levels = open_levels - 5'd1;
            closed = closed + 5'd1;
        end
        t.levels_closed = closed;
    endfunction

    function automatic void raise_error(inout out_item_t t, inout bit have, inout bit err,
                                        input kind_t k, input logic [7:0] b);
        have = 1;
        err = 1;
        t.kind = k;
        t.value = {56'd0, b};
        t.levels_closed = '0;
        t.top_done = 1'b0;
        clear_parser();
    endfunction

    function automatic void open_nest(inout out_item_t t, inout bit have, inout bit err,
                                      input kind_t k, input logic [63:0] cnt,
                                      input logic [32:0] elems, input logic [7:0] b);
        int lim;
        lim = (depth_limit < NEST) ? depth_limit : NEST;
        have = 1;
        t.kind = k;
        t.length = cnt[31:0];
        if (elems == 0)
            close_value(t);
        else if (open_levels >= lim)
            raise_error(t, have, err, K_DEEP, b);
        else
        begin
            rem_count[open_levels] = elems;
            open_levels = open_levels + 5'd1;
        end
    endfunction

    function automatic void open_raw(inout out_item_t t, inout bit have,
                                     input logic [32:0] cnt);
        have = 1;
        t.kind = K_BYTES;
        t.length = cnt[31:0];
        if (cnt == 0)
            close_value(t);
        else
        begin
            phase = PH_PAYLOAD;
            hdr_left = cnt;
        end
    endfunction

    function automatic void begin_header(input int n);
        phase = PH_HEADER;
        hdr_left = 33'(n);
        hdr_bits = '0;
    endfunction

    function automatic void predict_token(input in_item_t it);
        out_item_t   t;
        bit          have;
        bit          err;
        logic [7:0]  b;
        logic [63:0] v;
        b = it.data_byte;
        t = '0;
        have = 0;
        err = 0;
        t.depth = open_levels;
        if (phase == PH_HEADER)
        begin
            hdr_bits = (hdr_bits << 8) | {56'd0, b};
            hdr_left = hdr_left - 33'd1;
            if (hdr_left == 0)
            begin
                v = hdr_bits;
                phase = PH_LEADER;
                have = 1;
                case (cur_leader)
                    LD_F32: begin t.kind = K_F32; t.value = {32'd0, v[31:0]}; close_value(t); end
                    LD_F64: begin t.kind = K_F64; t.value = v; close_value(t); end
                    LD_U8, LD_U16, LD_U32, LD_U64:
                        begin t.kind = K_UINT; t.value = v; close_value(t); end
                    LD_I8:  begin t.kind = K_INT; t.value = sext(v, 8); close_value(t); end
                    LD_I16: begin t.kind = K_INT; t.value = sext(v, 16); close_value(t); end
                    LD_I32: begin t.kind = K_INT; t.value = sext(v, 32); close_value(t); end
                    LD_I64: begin t.kind = K_INT; t.value = v; close_value(t); end
                    LD_RAW16, LD_RAW32: open_raw(t, have, {1'b0, v[31:0]});
                    LD_ARR16, LD_ARR32:
                        open_nest(t, have, err, K_ARRAY, v, {1'b0, v[31:0]}, b);
                    LD_MAP16, LD_MAP32:
                        open_nest(t, have, err, K_MAP, v, {v[31:0], 1'b0}, b);
                    default: raise_error(t, have, err, K_BAD, b);
                endcase
            end
        end
        else if (phase == PH_PAYLOAD)
        begin
            have = 1;
            t.kind = K_BYTE;
            t.value = {56'd0, b};
            hdr_left = hdr_left - 33'd1;
            if (hdr_left == 0)
            begin
                phase = PH_LEADER;
                close_value(t);
            end
        end
        else
        begin
            cur_leader = b;
            if (b < LD_FIXMAP || b >= LD_NEGFIX)
            begin
                have = 1;
                t.kind = K_INT;
                t.value = sext({56'd0, b}, 8);
                close_value(t);
            end
            else if (b < LD_FIXARR)
                open_nest(t, have, err, K_MAP, {60'd0, b[3:0]}, {28'd0, b[3:0], 1'b0}, b);
            else if (b < LD_FIXRAW)
                open_nest(t, have, err, K_ARRAY, {60'd0, b[3:0]}, {29'd0, b[3:0]}, b);
            else if (b < LD_NIL)
                open_raw(t, have, {28'd0, b[4:0]});
            else
                case (b)
                    LD_NIL:   begin have = 1; t.kind = K_NIL; close_value(t); end
                    LD_FALSE: begin have = 1; t.kind = K_FALSE; close_value(t); end
                    LD_TRUE:  begin have = 1; t.kind = K_TRUE; close_value(t); end
                    LD_F32, LD_U32, LD_I32, LD_RAW32, LD_ARR32, LD_MAP32: begin_header(4);
                    LD_F64, LD_U64, LD_I64: begin_header(8);
                    LD_U8, LD_I8: begin_header(1);
                    LD_U16, LD_I16, LD_RAW16, LD_ARR16, LD_MAP16: begin_header(2);
                    default: raise_error(t, have, err, K_BAD, b);
                endcase
        end
        t.leader = cur_leader;
        if (it.last_byte && !err && (phase != PH_LEADER || open_levels != 0))
        begin
            t.depth = open_levels;
            t.length = '0;
            raise_error(t, have, err, K_TRUNC, b);
        end
        if (have)
            token_queue.push_back(t);
    endfunction

    // send one request; predict at acceptance; drop valid only for a gap
    task automatic send_byte(input logic [7:0] b, input bit last = 0);
        int gap;
        in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        if (!stall_quiet && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_token(it);
        byte_count++;
        @(negedge clk);
    endtask

    task automatic send_seq(input logic [7:0] bs[$]);
        foreach (bs[i])
            send_byte(bs[i]);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_quiet)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 40) == 0)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            out_ready <= ~out_ready;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            token_count++;
            if (token_queue.size() == 0)
            begin
                $display("%0t: unexpected token %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                exp = token_queue.pop_front();
                if (exp.kind !== out_data.kind || exp.value !== out_data.value ||
                    exp.length !== out_data.length || exp.leader !== out_data.leader ||
                    exp.depth !== out_data.depth ||
                    exp.levels_closed !== out_data.levels_closed ||
                    exp.top_done !== out_data.top_done)
                begin
                    $display("%0t: token mismatch expected %h actual %h", $time, exp, out_data);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (token_queue.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_depth(input logic [4:0] d);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {27'd0, d};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        depth_limit = d;
    endtask

    // a random well-formed value, nesting bounded by lvl
    task automatic send_value(input int lvl);
        int c;
        int n;
        c = $urandom_range(0, (lvl > 0) ? 9 : 6);
        case (c)
            0: send_byte(8'($urandom_range(0, 127)));
            1: send_byte(8'he0 | 8'($urandom_range(0, 31)));
            2: send_byte(($urandom_range(0, 2) == 0) ? LD_NIL : 8'(LD_NIL + $urandom_range(2, 3)));
            3:
            begin
                case ($urandom_range(0, 10))
                    0: begin send_byte(LD_F32); n = 4; end
                    1: begin send_byte(LD_F64); n = 8; end
                    2: begin send_byte(LD_U8); n = 1; end
                    3: begin send_byte(LD_U16); n = 2; end
                    4: begin send_byte(LD_U32); n = 4; end
                    5: begin send_byte(LD_U64); n = 8; end
                    6: begin send_byte(LD_I8); n = 1; end
                    7: begin send_byte(LD_I16); n = 2; end
                    8: begin send_byte(LD_I32); n = 4; end
                    default: begin send_byte(LD_I64); n = 8; end
                endcase
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            4, 5:
            begin
                n = $urandom_range(0, 6);
                send_byte(LD_FIXRAW | 8'(n));
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            6:
            begin
                n = $urandom_range(0, 5);
                if ($urandom_range(0, 1))
                begin
                    send_byte(LD_RAW16);
                    send_byte(8'h00);
                    send_byte(8'(n));
                end
                else
                begin
                    send_byte(LD_RAW32);
                    repeat (3) send_byte(8'h00);
                    send_byte(8'(n));
                end
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            7:
            begin
                n = $urandom_range(0, 4);
                send_byte(LD_FIXARR | 8'(n));
                repeat (n) send_value(lvl - 1);
            end
            8:
            begin
                n = $urandom_range(0, 3);
                send_byte(LD_FIXMAP | 8'(n));
                repeat (2 * n) send_value(lvl - 1);
            end
            default:
            begin
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 1))
                begin
                    send_byte(LD_ARR16);
                    send_byte(8'h00);
                    send_byte(8'(n));
                    repeat (n) send_value(lvl - 1);
                end
                else
                begin
                    send_byte(LD_MAP32);
                    repeat (3) send_byte(8'h00);
                    send_byte(8'(n));
                    repeat (2 * n) send_value(lvl - 1);
                end
            end
        endcase
    endtask

    task automatic test_scalars();
        send_seq('{8'h00, 8'h7f, 8'he0, 8'hff, LD_NIL, LD_FALSE, LD_TRUE});
        send_seq('{LD_U64, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_seq('{LD_I8, 8'h80, LD_I16, 8'h80, 8'h00, LD_I32, 8'h80, 8'h0, 8'h0, 8'h1});
        send_seq('{LD_F32, 8'h3f, 8'h80, 8'h00, 8'h00});
        send_seq('{LD_I64, 8'h80, 0, 0, 0, 0, 0, 0, 1, LD_F64, 1, 2, 3, 4, 5, 6, 7, 8});
        send_seq('{LD_U8, 8'hff, LD_U16, 8'hab, 8'hcd, LD_U32, 8'h12, 8'h34, 8'h56, 8'h78});
    endtask

    task automatic test_containers();
        send_seq('{8'h90, 8'h80, 8'ha0, LD_RAW16, 0, 0, LD_ARR32, 0, 0, 0, 0});
        send_seq('{8'h92, 8'h91, 8'h81, 8'h01, 8'ha2, 8'haa, 8'h55, LD_NIL});
        send_seq('{LD_MAP16, 0, 1, 8'hbf});
        repeat (31) send_byte(8'($urandom_range(0, 255)));
        send_seq('{LD_RAW32, 0, 0, 0, 1, 8'h00});
    endtask

    task automatic test_errors();
        send_seq('{8'hc1, 8'hc4, 8'hc9, 8'hd4, 8'hd9});
        send_seq('{8'h91, 8'h91, 8'hc7});
        send_byte(8'h92, 1);
        send_byte(LD_U16, 0);
        send_byte(8'h12, 1);
        send_byte(8'h05, 1);
        send_byte(8'ha3, 0);
        send_byte(8'h01, 1);
    endtask

    task automatic test_depth_limit(input logic [4:0] d);
        write_depth(d);
        repeat (18) send_byte(8'h91);
        send_byte(8'h91);
        send_byte(8'h90);
        send_seq('{LD_ARR16, 0, 2});
        repeat (16) send_byte(8'h91);
        send_byte(8'hc1);
        repeat (20) send_value(3);
    endtask

    task automatic test_random(input int target);
        int start;
        int r;
        start = byte_count;
        while (byte_count - start < target)
        begin
            stall_quiet = ($urandom_range(0, 15) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (r == 1)
            begin
                send_byte(8'h92);
                send_value(2);
                send_byte(8'($urandom_range(0, 255)), 1);
            end
            else
            begin
                send_value($urandom_range(0, 5));
                if ($urandom_range(0, 4) == 0)
                    send_byte(LD_NIL, 1);
            end
        end
        stall_quiet = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        token_count = 0;
        byte_count = 0;
        cycle_count = 0;
        stall_quiet = 0;
        cur_leader = '0;
        depth_limit = MAX_DEPTH_RST;
        clear_parser();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_scalars();
        test_containers();
        test_errors();
        test_depth_limit(5'd1);
        test_depth_limit(5'd31);
        test_depth_limit(5'd0);
        test_depth_limit(5'd3);
        write_depth(5'd16);
        test_random(700);
        write_depth(5'd2);
        test_random(300);
        write_depth(5'd8);
        test_random(300);
        drain();
        $display("sent %0d bytes, checked %0d tokens across depth limits 0..31",
                 byte_count, token_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
